// ===== rtl/rtme_pkg.sv =====
// radix tree map engine package: sizes, codes and sequencer states
// no dependencies
`default_nettype none
package rtme_pkg;
	localparam int SlotBits   = 4;
	localparam int MaxLevels  = 4;
	localparam int NodeCount  = 64;
	localparam int ItemBits   = 32;
	localparam int Slots      = 1 << SlotBits;
	localparam int NodeW      = $clog2(NodeCount);
	localparam int AddrW      = NodeW + SlotBits;
	localparam int LvlW       = $clog2(MaxLevels) + 1;

	typedef logic [NodeW-1:0] node_t;
	typedef logic [SlotBits-1:0] slot_t;

	localparam logic [1:0] ReqInsert = 2'd0;
	localparam logic [1:0] ReqLookup = 2'd1;
	localparam logic [1:0] ReqDelete = 2'd2;

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StNotFound = 2'd1;
	localparam logic [1:0] StExists   = 2'd2;
	localparam logic [1:0] StNoNodes  = 2'd3;

	localparam logic RegLevels = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROOT,
		S_WALK,
		S_RDWAIT,
		S_STEP,
		S_LEAF,
		S_LEAFRD,
		S_PRUNE,
		S_PLOAD,
		S_DONE
	} state_t;

	function automatic slot_t slot_of(input logic [15:0] key, input logic [LvlW-1:0] lvl);
		logic [31:0] sh;
		sh = 32'(key) >> (32'(lvl) * SlotBits);
		return sh[SlotBits-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/radix_tree_map_engine.sv =====
// radix tree map engine top level: request sequencer, node pool and slot memory
// depends on rtme_pkg
`default_nettype none
//  channel  | direction | handshake        | payload
//  request  | in        | req_valid/ready  | req_type, key, item_value
//  result   | out       | rsp_valid/ready  | status, found, item_out
//  config   | in        | apb psel/penable | levels at address 0
// a lookup or delete passes through WALK, RDWAIT and STEP for each level, an insert
// likewise for each level that already exists, while a freshly built level stays in
// WALK; pruning passes PRUNE and PLOAD for each freed node below the root and ends
// in PRUNE at the root or where the climb stops at a node still in use
// reset clears the pool bits and the root at once; a node record is written when
// the node is built and the slot store is only read behind a present bit, so
// neither memory needs a clearing pass
// the result is held in an output register; a stalled result holds the block
module radix_tree_map_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] key,
	input  wire logic [31:0] item_value,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [1:0]       status,
	output logic             found,
	output logic [31:0]      item_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int NW = rtme_pkg::NodeW;
	localparam int SB = rtme_pkg::SlotBits;
	localparam int LW = rtme_pkg::LvlW;
	localparam int NS = rtme_pkg::Slots;
	// node record: parent link (parent index + 1, slot in parent) above the present bits
	localparam int KW = NW + SB + 1;
	localparam int RW = KW + NS;

	rtme_pkg::state_t state_q, state_d;

	// slot memory, one write and one registered read per cycle
	logic [rtme_pkg::ItemBits-1:0] mem [rtme_pkg::NodeCount*rtme_pkg::Slots];
	logic [rtme_pkg::ItemBits-1:0] rd_q;
	logic                          mwe;
	logic [rtme_pkg::AddrW-1:0]    maddr;
	logic [rtme_pkg::ItemBits-1:0] mwdata;

	// node memory, written at the current node, read registered at nraddr
	logic [RW-1:0]   nmem [rtme_pkg::NodeCount];
	logic [RW-1:0]   nrd_q;
	logic            nwe;
	logic [RW-1:0]   nwdata;
	rtme_pkg::node_t nraddr;

	// working copy of the current node record
	logic [NS-1:0] cur_pres_q;
	logic [KW-1:0] cur_link_q;

	logic [rtme_pkg::NodeCount-1:0] used_q;
	logic [NW:0]                    root_q;
	logic [2:0]                     levels_q;

	logic [1:0]    rt_q;
	logic [15:0]   key_q;
	logic [31:0]   val_q;
	rtme_pkg::node_t n_q;
	logic [LW-1:0] lvl_q;
	logic [1:0]    st_q;
	logic          fnd_q;
	logic [31:0]   iout_q;

	logic [LW-1:0] eff_lvl;
	logic          cfg_wr;
	logic          cfg_hit;

	// lowest free node, priority search over the pool bits
	rtme_pkg::node_t free_idx;
	logic            free_ok;
	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = rtme_pkg::NodeCount - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = NW'(i);
				free_ok  = 1'b1;
			end
		end
	end

	always_comb begin
		if (levels_q == 3'd0) eff_lvl = LW'(1);
		else if (32'(levels_q) > rtme_pkg::MaxLevels) eff_lvl = LW'(rtme_pkg::MaxLevels);
		else eff_lvl = LW'(levels_q);
	end

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = (paddr[2] == rtme_pkg::RegLevels);
	assign pready  = 1'b1;
	assign prdata  = cfg_hit ? {29'd0, levels_q} : 32'd0;

	assign req_ready = (state_q == rtme_pkg::S_IDLE);
	assign rsp_valid = (state_q == rtme_pkg::S_DONE);
	assign status    = st_q;
	assign found     = fnd_q;
	assign item_out  = iout_q;

	rtme_pkg::slot_t idx;
	logic            pbit;
	logic [NS-1:0]   idx_bit;
	logic [NS-1:0]   up_bit;
	logic [NW:0]     up_link;
	logic            cur_free;
	assign idx      = rtme_pkg::slot_of(key_q, lvl_q);
	assign pbit     = cur_pres_q[idx];
	assign idx_bit  = NS'(1) << idx;
	// slot of the current node in its parent, and the parent index + 1
	assign up_bit   = NS'(1) << cur_link_q[SB-1:0];
	assign up_link  = cur_link_q[KW-1:SB];
	assign cur_free = used_q[n_q] && cur_pres_q == '0;

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= mwdata;
		rd_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (nwe) nmem[n_q] <= nwdata;
		nrd_q <= nmem[nraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rtme_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state and memory ports
	always_comb begin
		state_d = state_q;
		mwe     = 1'b0;
		maddr   = {n_q, idx};
		mwdata  = '0;
		nwe     = 1'b0;
		nwdata  = {cur_link_q, cur_pres_q};
		nraddr  = n_q;
		case (state_q)
			rtme_pkg::S_IDLE: begin
				// root record is ready the cycle after acceptance
				nraddr = NW'(root_q - 1'b1);
				if (req_valid) state_d = rtme_pkg::S_ROOT;
			end
			rtme_pkg::S_ROOT: begin
				if (rt_q == rtme_pkg::ReqInsert) begin
					if (root_q != '0 || free_ok) state_d = rtme_pkg::S_WALK;
					else state_d = rtme_pkg::S_DONE;
				end else if (rt_q == rtme_pkg::ReqLookup || rt_q == rtme_pkg::ReqDelete) begin
					state_d = (root_q != '0) ? rtme_pkg::S_WALK : rtme_pkg::S_DONE;
				end else state_d = rtme_pkg::S_DONE;
			end
			rtme_pkg::S_WALK: begin
				if (lvl_q == '0) state_d = rtme_pkg::S_LEAF;
				else if (pbit) state_d = rtme_pkg::S_RDWAIT;
				else if (rt_q != rtme_pkg::ReqInsert) state_d = rtme_pkg::S_DONE;
				else if (!free_ok) state_d = rtme_pkg::S_PRUNE;
				else begin
					// link a fresh child and write back the current node
					mwe     = 1'b1;
					mwdata  = 32'(free_idx);
					nwe     = 1'b1;
					nwdata  = {cur_link_q, cur_pres_q | idx_bit};
					state_d = rtme_pkg::S_WALK;
				end
			end
			rtme_pkg::S_RDWAIT: begin
				// child index is in rd_q, fetch its record
				nraddr  = rd_q[NW-1:0];
				state_d = rtme_pkg::S_STEP;
			end
			rtme_pkg::S_STEP: state_d = rtme_pkg::S_WALK;
			rtme_pkg::S_LEAF: begin
				if (rt_q == rtme_pkg::ReqInsert) begin
					if (!pbit) begin
						mwe    = 1'b1;
						mwdata = val_q;
						nwe    = 1'b1;
						nwdata = {cur_link_q, cur_pres_q | idx_bit};
					end
					state_d = rtme_pkg::S_DONE;
				end else state_d = pbit ? rtme_pkg::S_LEAFRD : rtme_pkg::S_DONE;
			end
			rtme_pkg::S_LEAFRD: begin
				if (rt_q == rtme_pkg::ReqDelete) begin
					nwe     = 1'b1;
					nwdata  = {cur_link_q, cur_pres_q & ~idx_bit};
					state_d = rtme_pkg::S_PRUNE;
				end else state_d = rtme_pkg::S_DONE;
			end
			rtme_pkg::S_PRUNE: begin
				if (!cur_free || up_link == '0) state_d = rtme_pkg::S_DONE;
				else begin
					nraddr  = NW'(up_link - 1'b1);
					state_d = rtme_pkg::S_PLOAD;
				end
			end
			rtme_pkg::S_PLOAD: begin
				// parent record arrives, drop the freed child's slot
				nwe     = 1'b1;
				nwdata  = {nrd_q[RW-1:NS], nrd_q[NS-1:0] & ~up_bit};
				state_d = rtme_pkg::S_PRUNE;
			end
			rtme_pkg::S_DONE: if (rsp_ready) state_d = rtme_pkg::S_IDLE;
			default: state_d = rtme_pkg::S_IDLE;
		endcase
	end

	// pool and root bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			root_q   <= '0;
			levels_q <= 3'd4;
		end else if (cfg_wr && cfg_hit) begin
			levels_q <= pwdata[2:0];
			used_q   <= '0;
			root_q   <= '0;
		end else begin
			case (state_q)
				rtme_pkg::S_ROOT: begin
					if (rt_q == rtme_pkg::ReqInsert && root_q == '0 && free_ok) begin
						used_q[free_idx] <= 1'b1;
						root_q           <= {1'b0, free_idx} + 1'b1;
					end
				end
				rtme_pkg::S_WALK: begin
					if (lvl_q != '0 && !pbit && rt_q == rtme_pkg::ReqInsert && free_ok)
						used_q[free_idx] <= 1'b1;
				end
				rtme_pkg::S_PRUNE: begin
					if (cur_free) begin
						used_q[n_q] <= 1'b0;
						if (up_link == '0) root_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// request registers, walk pointer and current node record
	always_ff @(posedge clk) begin
		case (state_q)
			rtme_pkg::S_IDLE: if (req_valid) begin
				rt_q   <= req_type;
				key_q  <= key;
				val_q  <= item_value;
				lvl_q  <= eff_lvl - 1'b1;
				st_q   <= rtme_pkg::StNotFound;
				fnd_q  <= 1'b0;
				iout_q <= '0;
			end
			rtme_pkg::S_ROOT: begin
				n_q        <= (root_q != '0) ? NW'(root_q - 1'b1) : free_idx;
				cur_pres_q <= (root_q != '0) ? nrd_q[NS-1:0] : '0;
				cur_link_q <= (root_q != '0) ? nrd_q[RW-1:NS] : '0;
				if (rt_q == rtme_pkg::ReqInsert && root_q == '0 && !free_ok)
					st_q <= rtme_pkg::StNoNodes;
			end
			rtme_pkg::S_WALK: begin
				if (lvl_q != '0 && !pbit && rt_q == rtme_pkg::ReqInsert) begin
					if (free_ok) begin
						n_q        <= free_idx;
						lvl_q      <= lvl_q - 1'b1;
						cur_pres_q <= '0;
						cur_link_q <= {{1'b0, n_q} + 1'b1, idx};
					end else st_q <= rtme_pkg::StNoNodes;
				end
			end
			rtme_pkg::S_STEP: begin
				n_q        <= rd_q[NW-1:0];
				lvl_q      <= lvl_q - 1'b1;
				cur_pres_q <= nrd_q[NS-1:0];
				cur_link_q <= nrd_q[RW-1:NS];
			end
			rtme_pkg::S_LEAF: begin
				if (rt_q == rtme_pkg::ReqInsert) st_q <= pbit ? rtme_pkg::StExists : rtme_pkg::StOk;
			end
			rtme_pkg::S_LEAFRD: begin
				st_q   <= rtme_pkg::StOk;
				fnd_q  <= 1'b1;
				iout_q <= rd_q;
				if (rt_q == rtme_pkg::ReqDelete) cur_pres_q <= cur_pres_q & ~idx_bit;
			end
			rtme_pkg::S_PRUNE: begin
				if (cur_free && up_link != '0)
					n_q <= NW'(up_link - 1'b1);
			end
			rtme_pkg::S_PLOAD: begin
				cur_pres_q <= nrd_q[NS-1:0] & ~up_bit;
				cur_link_q <= nrd_q[RW-1:NS];
			end
			default: ;
		endcase
	end

	// the result is never shown while a request is still being taken
	assert property (@(posedge clk) disable iff (!arst_n) !(req_ready && rsp_valid))
		else $error("ready and result valid together");
	// a found result always reports ok
	assert property (@(posedge clk) disable iff (!arst_n) rsp_valid && found |-> status == rtme_pkg::StOk)
		else $error("found without ok status");
	// an accepted request leaves idle
	assert property (@(posedge clk) disable iff (!arst_n) req_valid && req_ready |=> !req_ready)
		else $error("request accepted but still idle");
endmodule
`default_nettype wire
